FILE: src/assert_macros.svh
// Assertion macros used by the tracker top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/srbt_pkg.sv
// Types and constants shared by the retry and backoff tracker modules.
package srbt_pkg;

    localparam int SLOT_W      = 3;
    localparam int OUTCOME_W   = 2;
    localparam int TIME_BITS   = 48;
    localparam int INTERVAL_W  = 27;
    localparam int DELAY_W     = INTERVAL_W;
    localparam int CNT_W       = 8;
    localparam int BASE_W      = 16;
    localparam int CAP_W       = 24;
    localparam int SOFT_CAP_W  = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int MAX_SHIFT   = 16;
    localparam int SHIFT_W     = 5;
    localparam int SHIFTED_W   = BASE_W + MAX_SHIFT;
    localparam int QUEUE_DEPTH = 2;

    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_REARM  = 1'b1;

    localparam logic [OUTCOME_W-1:0] OUTC_SUCCESS = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTC_ABSENT  = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_SOFT_FAIL_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_LIMIT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_BASE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_CAP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT_RETRY_CAP  = 3'd4;

    localparam logic [CNT_W-1:0]      RST_SOFT_FAIL_LIMIT = 8'd3;
    localparam logic [CNT_W-1:0]      RST_STOP_LIMIT      = 8'd16;
    localparam logic [BASE_W-1:0]     RST_BACKOFF_BASE    = 16'd1000;
    localparam logic [CAP_W-1:0]      RST_BACKOFF_CAP     = 24'd300000;
    localparam logic [SOFT_CAP_W-1:0] RST_SOFT_RETRY_CAP  = 16'd5000;

    typedef enum logic [2:0] {
        ST_CONFIGURED  = 3'd0,
        ST_INITIALIZED = 3'd1,
        ST_POLLING     = 3'd2,
        ST_ABSENT      = 3'd3,
        ST_ERROR       = 3'd4,
        ST_FAILED      = 3'd5
    } run_state_t;

    typedef enum logic [2:0] {
        KIND_REARM,
        KIND_SUCCESS,
        KIND_FAIL_ABSENT,
        KIND_FAIL_OTHER,
        KIND_IGNORE
    } kind_t;

    typedef enum logic {
        BK_CALC,
        BK_WRITE
    } back_state_t;

    typedef struct packed {
        logic [CNT_W-1:0]      soft_fail_limit;
        logic [CNT_W-1:0]      stop_limit;
        logic [BASE_W-1:0]     backoff_base;
        logic [CAP_W-1:0]      backoff_cap;
        logic [SOFT_CAP_W-1:0] soft_retry_cap;
    } cfg_t;

    typedef struct packed {
        kind_t                 kind;
        logic [SLOT_W-1:0]     slot;
        logic [TIME_BITS-1:0]  now;
        logic [INTERVAL_W-1:0] interval;
    } cmd_t;

    typedef struct packed {
        logic [SLOT_W-1:0]    slot;
        run_state_t           run_state;
        logic                 next_is_init;
        logic [TIME_BITS-1:0] next_action;
        logic [TIME_BITS-1:0] next_retry;
        logic [CNT_W-1:0]     failure_count;
    } res_t;

endpackage

FILE: src/srbt_fifo.sv
// Small register queue used between the front and back parts and at the result side.
module srbt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == COUNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: src/srbt_front.sv
// Front part: decodes and classifies an incoming item into a queued command.
module srbt_front #(
    parameter int NUM_SLOTS = 8
) (
    input  logic                              op,
    input  logic [srbt_pkg::SLOT_W-1:0]       slot,
    input  logic [srbt_pkg::OUTCOME_W-1:0]    outcome,
    input  logic [srbt_pkg::TIME_BITS-1:0]    now_ms,
    input  logic [srbt_pkg::INTERVAL_W-1:0]   poll_period_ms,
    output srbt_pkg::cmd_t                    cmd
);
    import srbt_pkg::*;

    localparam logic [31:0] NUM_SLOTS_U = 32'(NUM_SLOTS);

    logic in_range;

    assign in_range = ({{(32 - SLOT_W){1'b0}}, slot} < NUM_SLOTS_U);

    always_comb
    begin
        cmd.slot     = slot;
        cmd.now      = now_ms;
        cmd.interval = poll_period_ms;
        if (!in_range)
        begin
            cmd.kind = KIND_IGNORE;
        end
        else if (op == OP_REARM)
        begin
            cmd.kind = KIND_REARM;
        end
        else if (outcome == OUTC_SUCCESS)
        begin
            cmd.kind = KIND_SUCCESS;
        end
        else if (outcome == OUTC_ABSENT)
        begin
            cmd.kind = KIND_FAIL_ABSENT;
        end
        else
        begin
            // Any other code, including the unused one, counts as an other failure.
            cmd.kind = KIND_FAIL_OTHER;
        end
    end

endmodule

FILE: src/srbt_back.sv
// Back part: holds the slot table and carries out one command in two steps.
module srbt_back #(
    parameter int NUM_SLOTS   = 8,
    parameter int SHIFT_LIMIT = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  srbt_pkg::cfg_t cfg,
    input  srbt_pkg::cmd_t cmd,
    input  logic           cmd_empty,
    output logic           cmd_pop,
    output srbt_pkg::res_t res,
    input  logic           res_full,
    output logic           res_push
);
    import srbt_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Slot table.
    logic                 ready_reg [NUM_SLOTS];
    logic [CNT_W-1:0]     pfr_reg   [NUM_SLOTS];
    logic [CNT_W-1:0]     ft_reg    [NUM_SLOTS];
    run_state_t           st_reg    [NUM_SLOTS];
    logic [TIME_BITS-1:0] due_reg   [NUM_SLOTS];

    back_state_t state_reg, state_next;

    // Registers between the decision step and the write step.
    logic [IDX_W-1:0]     idx_s_reg;
    logic [SLOT_W-1:0]    slot_s_reg;
    logic                 wr_s_reg;
    logic                 ignore_s_reg;
    logic                 rm_s_reg;
    logic [CNT_W-1:0]     pfr_s_reg;
    logic [CNT_W-1:0]     ft_s_reg;
    run_state_t           st_s_reg;
    logic                 sat_s_reg;
    logic [TIME_BITS-1:0] base_s_reg;
    logic [DELAY_W-1:0]   delay_s_reg;
    logic                 retry_s_reg;

    logic                 rm_next;
    logic [CNT_W-1:0]     pfr_next;
    logic [CNT_W-1:0]     ft_next;
    run_state_t           st_next;
    logic                 sat_next;
    logic [TIME_BITS-1:0] base_next;
    logic [DELAY_W-1:0]   delay_next;
    logic                 retry_next;
    logic                 wr_next;
    logic                 ignore_next;

    logic [IDX_W+SLOT_W-1:0] slot_ext;
    logic [IDX_W-1:0]        idx;
    logic                    rm_cur;
    logic [CNT_W-1:0]        pfr_cur;
    logic [CNT_W-1:0]        ft_cur;
    run_state_t              st_cur;
    logic [TIME_BITS-1:0]    due_cur;
    logic                    was_init;
    logic [CNT_W-1:0]        ft_inc;
    logic [CNT_W-1:0]        pfr_inc;
    logic                    soft_retry;
    logic                    hard_stop;
    logic [CNT_W-1:0]        shift_full;
    logic [SHIFT_W-1:0]      shift_amt;
    logic [SHIFTED_W-1:0]    shifted;
    logic [CAP_W-1:0]        backoff;
    logic [DELAY_W-1:0]      soft_delay;
    logic [TIME_BITS:0]      due_sum;
    logic [TIME_BITS-1:0]    due_new;
    logic                    stage_load;
    logic                    tbl_we;

    assign slot_ext = {{IDX_W{1'b0}}, cmd.slot};
    assign idx      = slot_ext[IDX_W-1:0];
    assign rm_cur   = ready_reg[idx];
    assign pfr_cur  = pfr_reg[idx];
    assign ft_cur   = ft_reg[idx];
    assign st_cur   = st_reg[idx];
    assign due_cur  = due_reg[idx];
    assign was_init = !rm_cur;

    assign ft_inc     = (ft_cur == '1) ? ft_cur : ft_cur + 1'b1;
    assign pfr_inc    = was_init ? pfr_cur : ((pfr_cur == '1) ? pfr_cur : pfr_cur + 1'b1);
    assign soft_retry = !was_init && (pfr_inc < cfg.soft_fail_limit);
    assign hard_stop  = (ft_inc >= cfg.stop_limit);

    // Backoff exponent is the failure count before this one, capped at SHIFT_LIMIT.
    assign shift_full = ft_inc - 1'b1;
    assign shift_amt  = (shift_full < CNT_W'(SHIFT_LIMIT)) ? shift_full[SHIFT_W-1:0]
                                                           : SHIFT_W'(SHIFT_LIMIT);
    assign shifted    = {{(SHIFTED_W - BASE_W){1'b0}}, cfg.backoff_base} << shift_amt;
    assign backoff    = (shifted < {{(SHIFTED_W - CAP_W){1'b0}}, cfg.backoff_cap})
                        ? shifted[CAP_W-1:0] : cfg.backoff_cap;
    assign soft_delay = (cmd.interval < {{(DELAY_W - SOFT_CAP_W){1'b0}}, cfg.soft_retry_cap})
                        ? cmd.interval : {{(DELAY_W - SOFT_CAP_W){1'b0}}, cfg.soft_retry_cap};

    always_comb
    begin
        rm_next     = rm_cur;
        pfr_next    = pfr_cur;
        ft_next     = ft_cur;
        st_next     = st_cur;
        sat_next    = 1'b0;
        base_next   = due_cur;
        delay_next  = '0;
        retry_next  = 1'b0;
        wr_next     = 1'b0;
        ignore_next = 1'b0;
        case (cmd.kind)
            KIND_IGNORE:
            begin
                ignore_next = 1'b1;
            end
            KIND_REARM:
            begin
                wr_next   = 1'b1;
                rm_next   = 1'b0;
                pfr_next  = '0;
                ft_next   = '0;
                st_next   = ST_CONFIGURED;
                base_next = cmd.now;
            end
            KIND_SUCCESS:
            begin
                if (st_cur != ST_FAILED)
                begin
                    wr_next    = 1'b1;
                    rm_next    = 1'b1;
                    pfr_next   = '0;
                    st_next    = was_init ? ST_INITIALIZED : ST_POLLING;
                    ft_next    = was_init ? ft_cur : '0;
                    base_next  = cmd.now;
                    delay_next = was_init ? '0 : cmd.interval;
                end
            end
            KIND_FAIL_ABSENT, KIND_FAIL_OTHER:
            begin
                if (st_cur != ST_FAILED)
                begin
                    wr_next = 1'b1;
                    st_next = (cmd.kind == KIND_FAIL_ABSENT) ? ST_ABSENT : ST_ERROR;
                    ft_next = ft_inc;
                    if (soft_retry)
                    begin
                        rm_next    = 1'b1;
                        pfr_next   = pfr_inc;
                        base_next  = cmd.now;
                        delay_next = soft_delay;
                        retry_next = 1'b1;
                    end
                    else
                    begin
                        rm_next  = 1'b0;
                        pfr_next = '0;
                        if (hard_stop)
                        begin
                            st_next  = ST_FAILED;
                            sat_next = 1'b1;
                        end
                        else
                        begin
                            base_next  = cmd.now;
                            delay_next = {{(DELAY_W - CAP_W){1'b0}}, backoff};
                            retry_next = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                ignore_next = 1'b1;
            end
        endcase
    end

    // Time sums saturate at all ones.
    assign due_sum = {1'b0, base_s_reg} + {{(TIME_BITS + 1 - DELAY_W){1'b0}}, delay_s_reg};
    assign due_new = (sat_s_reg || due_sum[TIME_BITS]) ? '1 : due_sum[TIME_BITS-1:0];

    always_comb
    begin
        res.slot = slot_s_reg;
        if (ignore_s_reg)
        begin
            res.run_state     = ST_CONFIGURED;
            res.next_is_init  = 1'b0;
            res.next_action   = '0;
            res.next_retry    = '0;
            res.failure_count = '0;
        end
        else
        begin
            res.run_state     = st_s_reg;
            res.next_is_init  = !rm_s_reg;
            res.next_action   = due_new;
            res.next_retry    = retry_s_reg ? due_new : '0;
            res.failure_count = ft_s_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        case (state_reg)
            BK_CALC:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    state_next = BK_WRITE;
                end
            end
            BK_WRITE:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = BK_CALC;
                end
            end
            default:
            begin
                state_next = BK_CALC;
            end
        endcase
    end

    assign stage_load = cmd_pop;
    assign tbl_we     = res_push && wr_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_CALC;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_load)
        begin
            idx_s_reg    <= idx;
            slot_s_reg   <= cmd.slot;
            wr_s_reg     <= wr_next;
            ignore_s_reg <= ignore_next;
            rm_s_reg     <= rm_next;
            pfr_s_reg    <= pfr_next;
            ft_s_reg     <= ft_next;
            st_s_reg     <= st_next;
            sat_s_reg    <= sat_next;
            base_s_reg   <= base_next;
            delay_s_reg  <= delay_next;
            retry_s_reg  <= retry_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                ready_reg[i] <= 1'b0;
                pfr_reg[i]   <= '0;
                ft_reg[i]    <= '0;
                st_reg[i]    <= ST_CONFIGURED;
                due_reg[i]   <= '0;
            end
        end
        else if (tbl_we)
        begin
            ready_reg[idx_s_reg] <= rm_s_reg;
            pfr_reg[idx_s_reg]   <= pfr_s_reg;
            ft_reg[idx_s_reg]    <= ft_s_reg;
            st_reg[idx_s_reg]    <= st_s_reg;
            due_reg[idx_s_reg]   <= due_new;
        end
    end

endmodule

FILE: src/sensor_retry_backoff_tracker.sv
// Top level of the per-slot sensor retry and backoff tracker.
// Input items enter through push/full: an item is taken when push is high and full is low.
// Each item re-arms a slot or reports the outcome of its last operation and yields
// exactly one result item, delivered in order through empty/pop.
// A result becomes visible (empty low) after its item passes the command queue, the back
// part's stage registers and the result queue. The back part works on one item at a time:
// it reads the slot table and decides, then adds the next action time and writes the table.
// A two-entry queue between the front and back parts absorbs short bursts.
// If the receiver stops popping, the two-entry result queue fills, the back part holds
// its finished item, and full rises once the command queue is full as well.
// Configuration registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data,
// always ready, and should only be written while the block is idle.
// Reset clears every slot to configured with zero counts and due time, loads the
// register defaults, and empties both queues; the block takes items at once.
`include "assert_macros.svh"

module sensor_retry_backoff_tracker #(
    parameter int NUM_SLOTS   = 8,
    parameter int SHIFT_LIMIT = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              op,
    input  logic [srbt_pkg::SLOT_W-1:0]       slot,
    input  logic [srbt_pkg::OUTCOME_W-1:0]    outcome,
    input  logic [srbt_pkg::TIME_BITS-1:0]    now_ms,
    input  logic [srbt_pkg::INTERVAL_W-1:0]   poll_period_ms,
    output logic                              empty,
    input  logic                              pop,
    output logic [srbt_pkg::SLOT_W-1:0]       slot_out,
    output logic [2:0]                        run_state,
    output logic                              next_is_init,
    output logic [srbt_pkg::TIME_BITS-1:0]    next_action_ms,
    output logic [srbt_pkg::TIME_BITS-1:0]    retry_at_ms,
    output logic [srbt_pkg::CNT_W-1:0]        failure_count,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [srbt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [srbt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import srbt_pkg::*;

    localparam int CMD_W = $bits(cmd_t);
    localparam int RES_W = $bits(res_t);

    cfg_t             cfg_reg;
    cmd_t             front_cmd;
    logic [CMD_W-1:0] mid_rdata;
    logic             cmd_empty;
    logic             cmd_pop;
    res_t             back_res;
    logic [RES_W-1:0] out_rdata;
    res_t             out_res;
    logic             res_full;
    logic             res_push;
    logic             failed_parked;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.soft_fail_limit <= RST_SOFT_FAIL_LIMIT;
            cfg_reg.stop_limit      <= RST_STOP_LIMIT;
            cfg_reg.backoff_base    <= RST_BACKOFF_BASE;
            cfg_reg.backoff_cap     <= RST_BACKOFF_CAP;
            cfg_reg.soft_retry_cap  <= RST_SOFT_RETRY_CAP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SOFT_FAIL_LIMIT: cfg_reg.soft_fail_limit <= cfg_data[CNT_W-1:0];
                CFG_STOP_LIMIT:      cfg_reg.stop_limit      <= cfg_data[CNT_W-1:0];
                CFG_BACKOFF_BASE:    cfg_reg.backoff_base    <= cfg_data[BASE_W-1:0];
                CFG_BACKOFF_CAP:     cfg_reg.backoff_cap     <= cfg_data[CAP_W-1:0];
                CFG_SOFT_RETRY_CAP:  cfg_reg.soft_retry_cap  <= cfg_data[SOFT_CAP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    srbt_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .op             (op),
        .slot           (slot),
        .outcome        (outcome),
        .now_ms         (now_ms),
        .poll_period_ms (poll_period_ms),
        .cmd            (front_cmd)
    );

    srbt_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_cmd),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (mid_rdata),
        .empty (cmd_empty)
    );

    srbt_back #(
        .NUM_SLOTS   (NUM_SLOTS),
        .SHIFT_LIMIT (SHIFT_LIMIT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd_t'(mid_rdata)),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res       (back_res),
        .res_full  (res_full),
        .res_push  (res_push)
    );

    srbt_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign out_res        = res_t'(out_rdata);
    assign slot_out       = out_res.slot;
    assign run_state      = out_res.run_state;
    assign next_is_init   = out_res.next_is_init;
    assign next_action_ms = out_res.next_action;
    assign retry_at_ms    = out_res.next_retry;
    assign failure_count  = out_res.failure_count;

    // A failed slot waits forever for a re-arm.
    assign failed_parked = (next_action_ms == '1) && (retry_at_ms == '0) && next_is_init;

    `ASSERT_IMPLIES(a_res_push_has_room, clk, rst_n, res_push, !res_full)
    `ASSERT_IMPLIES(a_cmd_pop_has_item, clk, rst_n, cmd_pop, !cmd_empty)
    `ASSERT_NEXT(a_res_push_spacing, clk, rst_n, res_push, !res_push)
    `ASSERT_IMPLIES(a_failed_slot_parked, clk, rst_n, !empty && run_state == ST_FAILED, failed_parked)

endmodule

FILE: tb/tb_sensor_retry_backoff_tracker.sv
// Self-checking testbench for the sensor retry and backoff tracker.
module tb_sensor_retry_backoff_tracker;
    import srbt_pkg::*;

    localparam int TRACK_SLOTS       = 8;
    localparam int TRACK_SHIFT_LIMIT = 8;
    localparam int CHUNK_ITEMS       = 100;
    localparam int SETTLE_CYCLES     = 4;
    localparam int CYCLE_LIMIT       = 400000;

    localparam logic [OUTCOME_W-1:0] OUTC_OTHER    = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUTC_RESERVED = 2'd3;

    localparam logic [TIME_BITS-1:0]  TIME_ALL_ONES = '1;
    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX  = '1;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic                  op;
        logic [SLOT_W-1:0]     slot;
        logic [OUTCOME_W-1:0]  outcome;
        logic [TIME_BITS-1:0]  now;
        logic [INTERVAL_W-1:0] interval;
    } sensor_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic                  op = 1'b0;
    logic [SLOT_W-1:0]     slot = '0;
    logic [OUTCOME_W-1:0]  outcome = '0;
    logic [TIME_BITS-1:0]  now_ms = '0;
    logic [INTERVAL_W-1:0] poll_period_ms = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [SLOT_W-1:0]     slot_out;
    logic [2:0]            run_state;
    logic                  next_is_init;
    logic [TIME_BITS-1:0]  next_action_ms;
    logic [TIME_BITS-1:0]  retry_at_ms;
    logic [CNT_W-1:0]      failure_count;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow of the slot table and the registers.
    logic                  ready_bit [TRACK_SLOTS];
    logic [CNT_W-1:0]      run_fails [TRACK_SLOTS];
    logic [CNT_W-1:0]      total_fails [TRACK_SLOTS];
    run_state_t            slot_st [TRACK_SLOTS];
    logic [TIME_BITS-1:0]  due [TRACK_SLOTS];
    logic [CNT_W-1:0]      lim_soft;
    logic [CNT_W-1:0]      lim_stop;
    logic [BASE_W-1:0]     base_ms;
    logic [CAP_W-1:0]      cap_ms;
    logic [SOFT_CAP_W-1:0] soft_cap_ms;

    sensor_item_t readings_pending [$];
    res_t         results_due [$];
    reg_write_t   reg_writes [$];

    idle_mode_t            idle_mode = IDLE_NONE;
    logic [TIME_BITS-1:0]  uptime_ms = '0;
    int                    mismatches = 0;
    int                    items_taken = 0;
    int                    results_checked = 0;
    int                    settings_used = 1;
    int                    cycles = 0;

    sensor_retry_backoff_tracker #(
        .NUM_SLOTS   (TRACK_SLOTS),
        .SHIFT_LIMIT (TRACK_SHIFT_LIMIT)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .op             (op),
        .slot           (slot),
        .outcome        (outcome),
        .now_ms         (now_ms),
        .poll_period_ms (poll_period_ms),
        .empty          (empty),
        .pop            (pop),
        .slot_out       (slot_out),
        .run_state      (run_state),
        .next_is_init   (next_is_init),
        .next_action_ms (next_action_ms),
        .retry_at_ms    (retry_at_ms),
        .failure_count  (failure_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [TIME_BITS-1:0] sat_time_sum(input logic [TIME_BITS-1:0] a,
                                                         input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? TIME_ALL_ONES : s[TIME_BITS-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] bump_count(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 8'd1;
    endfunction

    function automatic logic [TIME_BITS-1:0] backoff_delay(input logic [CNT_W-1:0] fails_before);
        logic [4:0]           sh;
        logic [TIME_BITS-1:0] d;
        sh = (fails_before < TRACK_SHIFT_LIMIT) ? fails_before[4:0] : 5'(TRACK_SHIFT_LIMIT);
        d = 48'(base_ms) << sh;
        return (d < 48'(cap_ms)) ? d : 48'(cap_ms);
    endfunction

    // Applies one item to the shadow table and returns the result it must produce.
    function automatic res_t advance_slot(input sensor_item_t it);
        res_t                 r;
        logic [TIME_BITS-1:0] retry;
        logic [TIME_BITS-1:0] soft_delay;
        logic                 was_init;
        int                   s;
        s = int'(it.slot);
        retry = '0;
        if (it.op == OP_REARM)
        begin
            ready_bit[s] = 1'b0;
            run_fails[s] = '0;
            total_fails[s] = '0;
            slot_st[s] = ST_CONFIGURED;
            due[s] = it.now;
        end
        else if (slot_st[s] != ST_FAILED)
        begin
            was_init = !ready_bit[s];
            if (it.outcome == OUTC_SUCCESS)
            begin
                ready_bit[s] = 1'b1;
                run_fails[s] = '0;
                if (was_init)
                begin
                    slot_st[s] = ST_INITIALIZED;
                    due[s] = it.now;
                end
                else
                begin
                    slot_st[s] = ST_POLLING;
                    total_fails[s] = '0;
                    due[s] = sat_time_sum(it.now, 48'(it.interval));
                end
            end
            else
            begin
                slot_st[s] = (it.outcome == OUTC_ABSENT) ? ST_ABSENT : ST_ERROR;
                total_fails[s] = bump_count(total_fails[s]);
                if (!was_init)
                    run_fails[s] = bump_count(run_fails[s]);
                if (!was_init && run_fails[s] < lim_soft)
                begin
                    // Soft poll failure: keep the driver and retry the poll soon.
                    soft_delay = (it.interval < 27'(soft_cap_ms)) ? 48'(it.interval)
                                                                   : 48'(soft_cap_ms);
                    ready_bit[s] = 1'b1;
                    due[s] = sat_time_sum(it.now, soft_delay);
                    retry = due[s];
                end
                else
                begin
                    ready_bit[s] = 1'b0;
                    run_fails[s] = '0;
                    if (total_fails[s] >= lim_stop)
                    begin
                        slot_st[s] = ST_FAILED;
                        due[s] = TIME_ALL_ONES;
                    end
                    else
                    begin
                        due[s] = sat_time_sum(it.now, backoff_delay(total_fails[s] - 8'd1));
                        retry = due[s];
                    end
                end
            end
        end
        r.slot = it.slot;
        r.run_state = slot_st[s];
        r.next_is_init = !ready_bit[s];
        r.next_action = due[s];
        r.next_retry = retry;
        r.failure_count = total_fails[s];
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [TIME_BITS-1:0] got,
                                 input logic [TIME_BITS-1:0] want);
        $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
        mismatches++;
    endtask

    task automatic queue_reading(input logic o, input logic [SLOT_W-1:0] s,
                                 input logic [OUTCOME_W-1:0] oc, input logic [TIME_BITS-1:0] t,
                                 input logic [INTERVAL_W-1:0] iv);
        sensor_item_t it;
        it.op = o;
        it.slot = s;
        it.outcome = oc;
        it.now = t;
        it.interval = iv;
        readings_pending.insert(readings_pending.size(), it);
    endtask

    task automatic queue_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] value);
        reg_write_t w;
        w.index = idx;
        w.data = value;
        reg_writes.insert(reg_writes.size(), w);
    endtask

    task automatic queue_random_reading(input int fail_pct);
        logic                  o;
        logic [OUTCOME_W-1:0]  oc;
        logic [TIME_BITS-1:0]  t;
        logic [INTERVAL_W-1:0] iv;
        logic [63:0]           wide;
        int                    pick;
        uptime_ms = uptime_ms + 48'($urandom_range(0, 3000));
        o = ($urandom_range(0, 99) < 6) ? OP_REARM : OP_REPORT;
        if ($urandom_range(0, 99) < fail_pct)
        begin
            pick = $urandom_range(0, 19);
            oc = (pick < 9) ? OUTC_ABSENT : (pick < 18) ? OUTC_OTHER : OUTC_RESERVED;
        end
        else
        begin
            oc = OUTC_SUCCESS;
        end
        wide = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 5)
            t = wide[TIME_BITS-1:0];
        else if (pick < 10)
            t = TIME_ALL_ONES - 48'($urandom_range(0, 20000));
        else
            t = uptime_ms;
        pick = $urandom_range(0, 9);
        case (pick)
            0: iv = '0;
            1: iv = wide[INTERVAL_W+31:32];
            2: iv = 27'($urandom_range(0, 86400000));
            default: iv = 27'($urandom_range(0, 12000));
        endcase
        queue_reading(o, 3'($urandom_range(0, TRACK_SLOTS - 1)), oc, t, iv);
    endtask

    task automatic wait_for_idle();
        while (readings_pending.size() != 0 || push || results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Sender side: register writes first, then items from the pending queue.
    always @(posedge clk or negedge rst_n)
    begin : feed_items
        sensor_item_t taken;
        sensor_item_t nxt;
        reg_write_t   w;
        logic         hold_off;
        if (!rst_n)
        begin
            push <= 1'b0;
            op <= 1'b0;
            slot <= '0;
            outcome <= '0;
            now_ms <= '0;
            poll_period_ms <= '0;
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                taken.op = op;
                taken.slot = slot;
                taken.outcome = outcome;
                taken.now = now_ms;
                taken.interval = poll_period_ms;
                results_due.insert(results_due.size(), advance_slot(taken));
                items_taken++;
            end
            if (!(push && full))
            begin
                case (idle_mode)
                    IDLE_SENDER: hold_off = ($urandom_range(0, 99) < 87);
                    IDLE_BOTH:   hold_off = ($urandom_range(0, 99) < 9);
                    default:     hold_off = 1'b0;
                endcase
                if (readings_pending.size() != 0 && !hold_off && !cfg_valid
                    && reg_writes.size() == 0)
                begin
                    nxt = readings_pending.pop_front();
                    push <= 1'b1;
                    op <= nxt.op;
                    slot <= nxt.slot;
                    outcome <= nxt.outcome;
                    now_ms <= nxt.now;
                    poll_period_ms <= nxt.interval;
                end
                else
                begin
                    push <= 1'b0;
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SOFT_FAIL_LIMIT: lim_soft = cfg_data[CNT_W-1:0];
                    CFG_STOP_LIMIT:      lim_stop = cfg_data[CNT_W-1:0];
                    CFG_BACKOFF_BASE:    base_ms = cfg_data[BASE_W-1:0];
                    CFG_BACKOFF_CAP:     cap_ms = cfg_data[CAP_W-1:0];
                    CFG_SOFT_RETRY_CAP:  soft_cap_ms = cfg_data[SOFT_CAP_W-1:0];
                    default: ;
                endcase
            end
            if (!(cfg_valid && !cfg_ready))
            begin
                if (reg_writes.size() != 0)
                begin
                    w = reg_writes.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= w.index;
                    cfg_data <= w.data;
                end
                else
                begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver side: check each popped result against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin : drain_results
        res_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (results_due.size() == 0)
                begin
                    note_mismatch("result with no item outstanding", 48'(slot_out), '0);
                end
                else
                begin
                    want = results_due.pop_front();
                    results_checked++;
                    if (slot_out !== want.slot)
                        note_mismatch("slot_out", 48'(slot_out), 48'(want.slot));
                    if (run_state !== want.run_state)
                        note_mismatch("run_state", 48'(run_state), 48'(want.run_state));
                    if (next_is_init !== want.next_is_init)
                        note_mismatch("next_is_init", 48'(next_is_init), 48'(want.next_is_init));
                    if (next_action_ms !== want.next_action)
                        note_mismatch("next_action_ms", next_action_ms, want.next_action);
                    if (retry_at_ms !== want.next_retry)
                        note_mismatch("retry_at_ms", retry_at_ms, want.next_retry);
                    if (failure_count !== want.failure_count)
                        note_mismatch("failure_count", 48'(failure_count),
                                      48'(want.failure_count));
                end
            end
            case (idle_mode)
                IDLE_RECEIVER: pop <= ($urandom_range(0, 99) >= 87);
                IDLE_BOTH:     pop <= ($urandom_range(0, 99) >= 9);
                default:       pop <= 1'b1;
            endcase
        end
    end

    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles", cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : run_phases
        int                    p;
        int                    c;
        int                    n;
        logic [CNT_W-1:0]      sfl;
        logic [CNT_W-1:0]      stl;
        logic [BASE_W-1:0]     bms;
        logic [CAP_W-1:0]      cms;
        logic [SOFT_CAP_W-1:0] scms;
        for (n = 0; n < TRACK_SLOTS; n++)
        begin
            ready_bit[n] = 1'b0;
            run_fails[n] = '0;
            total_fails[n] = '0;
            slot_st[n] = ST_CONFIGURED;
            due[n] = '0;
        end
        lim_soft = RST_SOFT_FAIL_LIMIT;
        lim_stop = RST_STOP_LIMIT;
        base_ms = RST_BACKOFF_BASE;
        cap_ms = RST_BACKOFF_CAP;
        soft_cap_ms = RST_SOFT_RETRY_CAP;

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (p = 0; p < 5; p++)
        begin
            if (p != 0)
            begin
                wait_for_idle();
                case (p)
                    1:
                    begin
                        sfl = 8'd1;
                        stl = 8'd255;
                        bms = '1;
                        cms = '1;
                        scms = '0;
                    end
                    2:
                    begin
                        sfl = 8'd255;
                        stl = 8'd1;
                        bms = 16'd1;
                        cms = 24'd1;
                        scms = '1;
                    end
                    // Zero limits: every poll failure is hard and fails the slot at once.
                    3:
                    begin
                        sfl = 8'd0;
                        stl = 8'd0;
                        bms = 16'd500;
                        cms = 24'd1000000;
                        scms = 16'd2500;
                    end
                    default:
                    begin
                        sfl = 8'($urandom_range(1, 6));
                        stl = 8'($urandom_range(2, 24));
                        bms = 16'($urandom_range(1, 65535));
                        cms = 24'($urandom_range(1, 16777215));
                        scms = 16'($urandom_range(0, 65535));
                    end
                endcase
                queue_reg_write(CFG_SOFT_FAIL_LIMIT, 24'(sfl));
                queue_reg_write(CFG_STOP_LIMIT, 24'(stl));
                queue_reg_write(CFG_BACKOFF_BASE, 24'(bms));
                queue_reg_write(CFG_BACKOFF_CAP, cms);
                queue_reg_write(CFG_SOFT_RETRY_CAP, 24'(scms));
                while (reg_writes.size() != 0 || cfg_valid) @(negedge clk);
                settings_used++;
            end

            idle_mode = IDLE_NONE;
            if (p == 0)
            begin
                // Init, poll, soft retries capped and uncapped, then a hard poll failure.
                queue_reading(OP_REPORT, 3'd0, OUTC_SUCCESS, 48'd100, 27'd1000);
                queue_reading(OP_REPORT, 3'd0, OUTC_SUCCESS, 48'd200, 27'd1000);
                queue_reading(OP_REPORT, 3'd0, OUTC_ABSENT, 48'd300, 27'd2000);
                queue_reading(OP_REPORT, 3'd0, OUTC_OTHER, 48'd400, 27'd80000000);
                queue_reading(OP_REPORT, 3'd0, OUTC_RESERVED, 48'd500, 27'd10);
                // Init failures back off, init success keeps the count, poll success clears it.
                queue_reading(OP_REPORT, 3'd1, OUTC_ABSENT, 48'd0, 27'd0);
                queue_reading(OP_REPORT, 3'd1, OUTC_OTHER, 48'd0, 27'd0);
                queue_reading(OP_REPORT, 3'd1, OUTC_SUCCESS, 48'd10, 27'd50);
                queue_reading(OP_REPORT, 3'd1, OUTC_SUCCESS, 48'd20, 27'd50);
                // Times at the top of the range saturate.
                queue_reading(OP_REARM, 3'd2, OUTC_SUCCESS, TIME_ALL_ONES, INTERVAL_MAX);
                queue_reading(OP_REPORT, 3'd2, OUTC_SUCCESS, TIME_ALL_ONES, INTERVAL_MAX);
                queue_reading(OP_REPORT, 3'd2, OUTC_SUCCESS, TIME_ALL_ONES - 48'd3,
                              INTERVAL_MAX);
                queue_reading(OP_REPORT, 3'd2, OUTC_ABSENT, TIME_ALL_ONES, 27'd100);
                queue_reading(OP_REPORT, 3'd7, OUTC_OTHER, 48'h8000_0000_0000, 27'd0);
                queue_reading(OP_REARM, 3'd7, OUTC_RESERVED, 48'd0, 27'd0);
                queue_reading(OP_REPORT, 3'd7, OUTC_RESERVED, TIME_ALL_ONES - 48'd1, 27'd7);
            end
            else if (p == 3)
            begin
                queue_reading(OP_REARM, 3'd4, OUTC_SUCCESS, 48'd50, 27'd100);
                queue_reading(OP_REPORT, 3'd4, OUTC_SUCCESS, 48'd60, 27'd100);
                queue_reading(OP_REPORT, 3'd4, OUTC_ABSENT, 48'd70, 27'd100);
                // A report to a failed slot is ignored.
                queue_reading(OP_REPORT, 3'd4, OUTC_SUCCESS, 48'd80, 27'd100);
                queue_reading(OP_REARM, 3'd4, OUTC_OTHER, 48'd90, 27'd100);
                queue_reading(OP_REPORT, 3'd5, OUTC_RESERVED, 48'd95, 27'd5);
            end
            while (readings_pending.size() != 0) @(negedge clk);

            for (c = 0; c < 3; c++)
            begin
                idle_mode = idle_mode_t'((p + c) % 4);
                repeat (CHUNK_ITEMS) queue_random_reading((c == 0) ? 30 : (c == 1) ? 60 : 85);
                while (readings_pending.size() != 0) @(negedge clk);
            end
        end

        idle_mode = IDLE_NONE;
        wait_for_idle();
        repeat (8) @(negedge clk);
        if (results_due.size() != 0)
            note_mismatch("results never delivered", 48'(results_due.size()), '0);
        $display("Checked %0d results from %0d items under %0d register settings,",
                 results_checked, items_taken, settings_used);
        $display("with no idling, sender gaps, receiver stalls and both together.");
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
